// File: rtl/spectrum_band_averager_core_defines.svh
// Assertion macros for the spectrum band averager RTL.
`ifndef SPECTRUM_BAND_AVERAGER_CORE_DEFINES_SVH
`define SPECTRUM_BAND_AVERAGER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SBA_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SBA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sba_pkg.sv
// Package: types, constants and band lookup for the spectrum band averager.
package sba_pkg;

    localparam int BAND_COUNT   = 10;
    localparam int FRAME_LENGTH = 1024;
    localparam int BIN_MIN      = 2;

    localparam int BIN_W  = 9;
    localparam int MAG_W  = 24;
    localparam int SUM_W  = 33;
    localparam int ACC_W  = 41;
    localparam int FC_W   = 8;
    localparam int BAND_W = 4;
    localparam int CFG_W  = 24;
    localparam int CFG_IDX_W = 1;

    localparam int DIV_STEPS = ACC_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Frame-end settle: token walk through all cells, then the halve-and-merge and accumulate.
    localparam int CLOSE_CYCLES = BAND_COUNT + 2;
    localparam int CLOSE_CNT_W  = $clog2(CLOSE_CYCLES + 1);

    localparam logic [MAG_W-1:0] THRESH_RESET = 24'd500;
    localparam logic [FC_W-1:0]  FPA_RESET    = 8'd100;

    localparam logic [CFG_IDX_W-1:0] REG_NOISE_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_AVG  = 1'd1;

    localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(BAND_COUNT - 1);

    // Inclusive upper edges of bands 0..8; band 9 takes the rest.
    localparam logic [BIN_W-1:0] BAND_TOP [0:BAND_COUNT-2] =
        '{9'd3, 9'd5, 9'd9, 9'd15, 9'd26, 9'd45, 9'd79, 9'd138, 9'd242};

    typedef struct packed {
        logic [BIN_W-1:0] bin_index;
        logic [MAG_W-1:0] magnitude;
        logic             frame_end;
    } in_beat_t;

    typedef struct packed {
        logic [BAND_W-1:0] band_number;
        logic [SUM_W-1:0]  band_average;
        logic              last_band;
    } out_beat_t;

    // Bin traveling down the cell row.
    typedef struct packed {
        logic              valid;
        logic              add;
        logic [BAND_W-1:0] band;
        logic [MAG_W-1:0]  mag;
        logic              fend;
    } lane_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_LOAD,
        ST_DIV,
        ST_PUT
    } state_t;

    function automatic logic [BAND_W-1:0] band_of(input logic [BIN_W-1:0] bin);
        logic [BAND_W-1:0] b;
        b = LAST_BAND;
        for (int i = BAND_COUNT - 2; i >= 0; i--)
        begin
            if (bin <= BAND_TOP[i])
            begin
                b = BAND_W'(i);
            end
        end
        return b;
    endfunction

endpackage

// File: rtl/sba_cell.sv
// Band cell: per-band sum, smoothed height and long-term accumulator.
module sba_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [sba_pkg::BAND_W-1:0] cell_id,
    input  sba_pkg::lane_t           lane_in,
    output sba_pkg::lane_t           lane_out,
    input  logic                     shift_en,
    input  logic [sba_pkg::ACC_W-1:0] acc_in,
    output logic [sba_pkg::ACC_W-1:0] acc_out
);

    logic [sba_pkg::SUM_W-1:0] sum_reg;
    logic [sba_pkg::SUM_W-1:0] sh_reg;
    logic [sba_pkg::ACC_W-1:0] acc_reg;
    logic                      close_reg;
    logic                      pend_reg;
    sba_pkg::lane_t            lane_reg;

    logic                      hit;
    logic [sba_pkg::SUM_W:0]   sum_wide;
    logic [sba_pkg::SUM_W-1:0] sum_sat;
    logic [sba_pkg::SUM_W:0]   sh_wide;

    always_comb
    begin
        hit      = lane_in.valid && lane_in.add && (lane_in.band == cell_id);
        sum_wide = {1'b0, sum_reg} + (sba_pkg::SUM_W + 1)'(lane_in.mag);
        sum_sat  = sum_wide[sba_pkg::SUM_W] ? '1 : sum_wide[sba_pkg::SUM_W-1:0];
        sh_wide  = {1'b0, sh_reg} + {1'b0, sum_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            sh_reg    <= '0;
            acc_reg   <= '0;
            close_reg <= 1'b0;
            pend_reg  <= 1'b0;
            lane_reg  <= '0;
        end
        else
        begin
            lane_reg  <= lane_in;
            close_reg <= lane_in.valid && lane_in.fend;
            pend_reg  <= close_reg;

            // frame end: bin added first, then halve-and-merge, then accumulate
            if (close_reg)
            begin
                sum_reg <= '0;
                sh_reg  <= sh_wide[sba_pkg::SUM_W:1];
            end
            else if (hit)
            begin
                sum_reg <= sum_sat;
            end

            if (shift_en)
            begin
                acc_reg <= acc_in;
            end
            else if (pend_reg)
            begin
                acc_reg <= acc_reg + sba_pkg::ACC_W'(sh_reg);
            end
        end
    end

    assign lane_out = lane_reg;
    assign acc_out  = acc_reg;

endmodule

// File: rtl/sba_div.sv
// Restoring divider: one quotient bit per cycle, accumulator over frame count.
module sba_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sba_pkg::ACC_W-1:0] dividend,
    input  logic [sba_pkg::FC_W-1:0]  divisor,
    output logic                      busy,
    output logic [sba_pkg::SUM_W-1:0] quotient
);

    logic [sba_pkg::ACC_W-1:0]     quo_reg;
    logic [sba_pkg::FC_W-1:0]      rem_reg;
    logic [sba_pkg::FC_W-1:0]      dvs_reg;
    logic [sba_pkg::DIV_CNT_W-1:0] step_reg;
    logic                          busy_reg;

    logic [sba_pkg::FC_W:0]   rem_sh;
    logic [sba_pkg::FC_W:0]   rem_sub;
    logic                     ge;

    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[sba_pkg::ACC_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        ge      = rem_sh >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= sba_pkg::DIV_CNT_W'(sba_pkg::DIV_STEPS);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            busy_reg <= (step_reg != sba_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[sba_pkg::ACC_W-2:0], ge};
            // remainder stays below the divisor, so it fits back in FC_W bits
            rem_reg <= ge ? rem_sub[sba_pkg::FC_W-1:0] : rem_sh[sba_pkg::FC_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg[sba_pkg::SUM_W-1:0];

endmodule

// File: rtl/spectrum_band_averager_core.sv
// Top level: spectrum band averager, a row of band cells and a shared divider.
// Throughput: one bin beat per cycle inside a frame. Each bin walks the ten-cell row,
// one cell per cycle; a frame-end beat holds off input while it settles. A report then
// runs band by band (load, divider steps, a done check, output write) and waits on output
// stall. Input stays held off until it ends; out_valid rises after the first output write.
// Reset (rst_n, async low): all sums, heights, accumulators and the frame counter clear;
// threshold resets to 500 and frames per report to 100.
`include "spectrum_band_averager_core_defines.svh"

module spectrum_band_averager_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  sba_pkg::in_beat_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output sba_pkg::out_beat_t                out_data,
    input  logic                              cfg_we,
    input  logic [sba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sba_pkg::CFG_W-1:0]         cfg_data
);

    // Configuration registers
    logic [sba_pkg::MAG_W-1:0] thresh_reg;
    logic [sba_pkg::FC_W-1:0]  fpa_reg;

    // Control
    sba_pkg::state_t               state_reg, state_next;
    logic [sba_pkg::CLOSE_CNT_W-1:0] wait_reg;
    logic [sba_pkg::FC_W-1:0]      fc_reg;
    logic                          rpt_reg;
    logic [sba_pkg::BAND_W-1:0]    band_reg;

    // Output register
    logic                          out_valid_reg;
    sba_pkg::out_beat_t            out_data_reg;

    logic                          in_fire;
    logic                          div_start;
    logic                          chain_shift;
    logic                          put_fire;
    logic                          div_busy;
    logic [sba_pkg::SUM_W-1:0]     div_quo;

    logic [sba_pkg::FC_W-1:0]      fc_inc;
    logic [sba_pkg::FC_W-1:0]      fc_target;
    logic                          rpt_due;

    sba_pkg::lane_t                lane [0:sba_pkg::BAND_COUNT];
    logic [sba_pkg::ACC_W-1:0]     acc_chain [0:sba_pkg::BAND_COUNT];
    logic [sba_pkg::BAND_COUNT-1:0] lane_busy;

    assign in_fire = in_valid && in_ready;

    // Bin qualification: in range and strictly above the noise floor
    always_comb
    begin
        lane[0].valid = in_fire;
        lane[0].add   = (32'(in_data.bin_index) >= 32'(sba_pkg::BIN_MIN))
                     && (32'(in_data.bin_index) < 32'(sba_pkg::FRAME_LENGTH / 2))
                     && (in_data.magnitude > thresh_reg);
        lane[0].band  = sba_pkg::band_of(in_data.bin_index);
        lane[0].mag   = in_data.magnitude;
        lane[0].fend  = in_data.frame_end;
    end

    // Report decision at frame end; register value 0 acts as 1, counter wrap skips report
    always_comb
    begin
        fc_inc    = fc_reg + 1'b1;
        fc_target = (fpa_reg == '0) ? sba_pkg::FC_W'(1) : fpa_reg;
        rpt_due   = (fc_inc != '0) && (fc_inc >= fc_target);
    end

    // Cell row: bins flow toward the last cell; on report, accumulators
    // shift toward cell 0, which feeds the divider, and zeros enter at the tail.
    assign acc_chain[sba_pkg::BAND_COUNT] = '0;

    for (genvar i = 0; i < sba_pkg::BAND_COUNT; i++)
    begin : g_cell
        sba_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_id  (sba_pkg::BAND_W'(i)),
            .lane_in  (lane[i]),
            .lane_out (lane[i+1]),
            .shift_en (chain_shift),
            .acc_in   (acc_chain[i+1]),
            .acc_out  (acc_chain[i])
        );
        assign lane_busy[i] = lane[i+1].valid;
    end

    sba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_chain[0]),
        .divisor  (fc_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sba_pkg::ST_IDLE:
            begin
                if (in_fire && in_data.frame_end)
                begin
                    state_next = sba_pkg::ST_CLOSE;
                end
            end
            sba_pkg::ST_CLOSE:
            begin
                if (wait_reg == '0)
                begin
                    state_next = rpt_reg ? sba_pkg::ST_LOAD : sba_pkg::ST_IDLE;
                end
            end
            sba_pkg::ST_LOAD:
            begin
                state_next = sba_pkg::ST_DIV;
            end
            sba_pkg::ST_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = sba_pkg::ST_PUT;
                end
            end
            sba_pkg::ST_PUT:
            begin
                if (put_fire)
                begin
                    state_next = (band_reg == sba_pkg::LAST_BAND) ? sba_pkg::ST_IDLE
                                                                   : sba_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = sba_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready    = 1'b0;
        div_start   = 1'b0;
        chain_shift = 1'b0;
        put_fire    = 1'b0;
        case (state_reg)
            sba_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            sba_pkg::ST_LOAD:
            begin
                div_start   = 1'b1;
                chain_shift = 1'b1;
            end
            sba_pkg::ST_PUT:
            begin
                put_fire = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sba_pkg::ST_IDLE;
            wait_reg      <= '0;
            fc_reg        <= '0;
            rpt_reg       <= 1'b0;
            band_reg      <= '0;
            out_valid_reg <= 1'b0;
            thresh_reg    <= sba_pkg::THRESH_RESET;
            fpa_reg       <= sba_pkg::FPA_RESET;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    sba_pkg::REG_NOISE_THRESHOLD: thresh_reg <= cfg_data;
                    sba_pkg::REG_FRAMES_PER_AVG:  fpa_reg    <= cfg_data[sba_pkg::FC_W-1:0];
                    default:                      thresh_reg <= thresh_reg;
                endcase
            end

            if (in_fire && in_data.frame_end)
            begin
                fc_reg   <= fc_inc;
                rpt_reg  <= rpt_due;
                wait_reg <= sba_pkg::CLOSE_CNT_W'(sba_pkg::CLOSE_CYCLES - 1);
                band_reg <= '0;
            end
            else if (state_reg == sba_pkg::ST_CLOSE)
            begin
                wait_reg <= wait_reg - 1'b1;
            end

            if (put_fire)
            begin
                band_reg <= band_reg + 1'b1;
                if (band_reg == sba_pkg::LAST_BAND)
                begin
                    fc_reg <= '0;
                end
            end

            // output beat register: refill on put, drop on take
            if (put_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (put_fire)
        begin
            out_data_reg.band_number  <= band_reg;
            out_data_reg.band_average <= div_quo;
            out_data_reg.last_band    <= (band_reg == sba_pkg::LAST_BAND);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    `SBA_ASSERT_NOW(a_row_empty_on_load, state_reg == sba_pkg::ST_LOAD, lane_busy == '0,
        "bin still in cell row when report starts")
    `SBA_ASSERT_NOW(a_div_idle_on_load, state_reg == sba_pkg::ST_LOAD, !div_busy,
        "divider restarted while busy")
    `SBA_ASSERT_NEXT(a_count_clear, put_fire && band_reg == sba_pkg::LAST_BAND,
        fc_reg == '0 && state_reg == sba_pkg::ST_IDLE,
        "frame count not cleared after report")
    `SBA_ASSERT_NOW(a_divisor_nonzero, state_reg == sba_pkg::ST_LOAD, fc_reg != '0,
        "report with zero frame count")

endmodule

// File: tb/sv/tb_spectrum_band_averager_core.sv
// Self-checking testbench for the spectrum band averager core.
`timescale 1ns / 100ps

module tb_spectrum_band_averager_core;

    localparam int HALF_PERIOD = 6;
    // Bins walk ten cells and the frame end then settles; the wait also covers
    // the first average, which shows up after the frame-end beat.
    localparam int SETTLE_CYCLES = 64;
    // Worst case is every beat a frame end with a report behind it, for about
    // 400 beats, plus stalls. Leave a wide margin.
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [sba_pkg::MAG_W-1:0] MAG_MAX = '1;

    // Inclusive upper bin of bands 0..8; band 9 takes everything above.
    localparam int BAND_EDGE [9] = '{3, 5, 9, 15, 26, 45, 79, 138, 242};

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mix_t;

    // Tracks the band state of the block and queues the averages each
    // report should produce.
    class band_report_board;
        bit [sba_pkg::SUM_W-1:0]  band_sum [sba_pkg::BAND_COUNT];
        bit [sba_pkg::SUM_W-1:0]  height [sba_pkg::BAND_COUNT];
        bit [sba_pkg::ACC_W-1:0]  height_total [sba_pkg::BAND_COUNT];
        bit [sba_pkg::FC_W-1:0]   frames_seen;
        bit [sba_pkg::MAG_W-1:0]  threshold;
        bit [sba_pkg::FC_W-1:0]   frames_per_report;
        sba_pkg::out_beat_t       pending_averages [$];
        int                       errors;
        int                       averages_checked;
        int                       reports;

        function void clear();
            for (int i = 0; i < sba_pkg::BAND_COUNT; i++)
            begin
                band_sum[i] = '0;
                height[i] = '0;
                height_total[i] = '0;
            end
            frames_seen = '0;
            threshold = sba_pkg::THRESH_RESET;
            frames_per_report = sba_pkg::FPA_RESET;
            pending_averages.delete();
        endfunction

        function void write_reg(logic [sba_pkg::CFG_IDX_W-1:0] idx,
                                logic [sba_pkg::CFG_W-1:0] val);
            if (idx == sba_pkg::REG_NOISE_THRESHOLD)
                threshold = val[sba_pkg::MAG_W-1:0];
            else if (idx == sba_pkg::REG_FRAMES_PER_AVG)
                frames_per_report = val[sba_pkg::FC_W-1:0];
        endfunction

        function int band_for(logic [sba_pkg::BIN_W-1:0] bin);
            for (int i = 0; i < 9; i++)
            begin
                if (int'(bin) <= BAND_EDGE[i])
                    return i;
            end
            return sba_pkg::BAND_COUNT - 1;
        endfunction

        function int pending();
            return pending_averages.size();
        endfunction

        // Accepted bin beat: bin it, close the frame on frame_end, and queue
        // a report once enough frames are in.
        function void take_bin(sba_pkg::in_beat_t beat);
            int k;
            bit [sba_pkg::SUM_W:0] wide_sum;
            bit [sba_pkg::FC_W-1:0] target;
            sba_pkg::out_beat_t avg;
            // every 9-bit bin is below FRAME_LENGTH/2, only bins 0 and 1 drop out
            if (beat.bin_index >= sba_pkg::BIN_MIN &&
                int'(beat.bin_index) < sba_pkg::FRAME_LENGTH / 2 &&
                beat.magnitude > threshold)
            begin
                k = band_for(beat.bin_index);
                wide_sum = {1'b0, band_sum[k]} + beat.magnitude;
                band_sum[k] = wide_sum[sba_pkg::SUM_W] ? '1 : wide_sum[sba_pkg::SUM_W-1:0];
            end
            if (!beat.frame_end)
                return;
            for (int i = 0; i < sba_pkg::BAND_COUNT; i++)
            begin
                wide_sum = {1'b0, height[i]} + {1'b0, band_sum[i]};
                height[i] = wide_sum[sba_pkg::SUM_W:1];
                height_total[i] = height_total[i] + height[i];
                band_sum[i] = '0;
            end
            frames_seen = frames_seen + 1'b1;
            target = (frames_per_report == 0) ? 8'd1 : frames_per_report;
            if (frames_seen == 0 || frames_seen < target)
                return;
            for (int i = 0; i < sba_pkg::BAND_COUNT; i++)
            begin
                avg.band_number = sba_pkg::BAND_W'(i);
                avg.band_average = sba_pkg::SUM_W'(height_total[i] / frames_seen);
                avg.last_band = (i == sba_pkg::BAND_COUNT - 1);
                pending_averages.push_back(avg);
                height_total[i] = '0;
            end
            frames_seen = '0;
            reports++;
        endfunction

        function void match_average(sba_pkg::out_beat_t got);
            sba_pkg::out_beat_t want;
            if (pending_averages.size() == 0)
            begin
                $error("average beat with none expected: band_number %0d band_average %0d",
                       got.band_number, got.band_average);
                errors++;
                return;
            end
            want = pending_averages.pop_front();
            averages_checked++;
            if (got.band_number !== want.band_number)
            begin
                $error("band_number: expected %0d, got %0d", want.band_number, got.band_number);
                errors++;
            end
            if (got.band_average !== want.band_average)
            begin
                $error("band_average (band %0d): expected %0d, got %0d",
                       want.band_number, want.band_average, got.band_average);
                errors++;
            end
            if (got.last_band !== want.last_band)
            begin
                $error("last_band (band %0d): expected %0d, got %0d",
                       want.band_number, want.last_band, got.last_band);
                errors++;
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    sba_pkg::in_beat_t             in_data;
    logic                          out_valid;
    logic                          out_ready;
    sba_pkg::out_beat_t            out_data;
    logic                          cfg_we;
    logic [sba_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sba_pkg::CFG_W-1:0]     cfg_data;

    band_report_board sb;
    int send_idle_pct;
    int recv_stall_pct;
    int beats_sent;
    int cycle_count;

    spectrum_band_averager_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    // Receiver side: random back-pressure per the current idle mix.
    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.match_average(out_data);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d averages still owed",
                     cycle_count, sb.pending());
            $display("FAIL");
            $finish;
        end
    end

    task automatic set_idle_mix(idle_mix_t mix);
        case (mix)
            IDLE_SENDER:   begin send_idle_pct = 56; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            IDLE_BOTH:     begin send_idle_pct = 7;  recv_stall_pct = 7;  end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // One bin beat: optional idle cycles, then hold valid until accepted.
    task automatic send_beat(sba_pkg::in_beat_t beat);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.take_bin(beat);
        beats_sent++;
    endtask

    task automatic send_bin(int bin, logic [sba_pkg::MAG_W-1:0] mag, bit fend);
        sba_pkg::in_beat_t beat;
        beat.bin_index = sba_pkg::BIN_W'(bin);
        beat.magnitude = mag;
        beat.frame_end = fend;
        send_beat(beat);
    endtask

    // Drop valid and hold off until every owed average is out and the
    // cell row has emptied.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [sba_pkg::CFG_IDX_W-1:0] idx,
                             logic [sba_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(logic [sba_pkg::MAG_W-1:0] thr,
                                  logic [sba_pkg::FC_W-1:0] fpa);
        drain();
        write_reg(sba_pkg::REG_NOISE_THRESHOLD, sba_pkg::CFG_W'(thr));
        write_reg(sba_pkg::REG_FRAMES_PER_AVG, sba_pkg::CFG_W'(fpa));
    endtask

    function automatic int draw_bin();
        int k;
        int lo;
        int hi;
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1);
            1, 2, 3, 4: return $urandom_range(0, 511);
            default:
            begin
                k = $urandom_range(0, sba_pkg::BAND_COUNT - 1);
                lo = (k == 0) ? sba_pkg::BIN_MIN : BAND_EDGE[k-1] + 1;
                hi = (k == sba_pkg::BAND_COUNT - 1) ? 511 : BAND_EDGE[k];
                return $urandom_range(lo, hi);
            end
        endcase
    endfunction

    // Magnitudes cluster around the threshold so both sides of the gate show up.
    function automatic logic [sba_pkg::MAG_W-1:0] draw_magnitude(
        logic [sba_pkg::MAG_W-1:0] thr);
        case ($urandom_range(0, 6))
            0:       return thr;
            1:       return (thr == MAG_MAX) ? thr : thr + 1'b1;
            2:       return (thr == 0) ? thr : thr - 1'b1;
            3:       return MAG_MAX;
            4:       return sba_pkg::MAG_W'($urandom_range(0, 1023));
            default: return sba_pkg::MAG_W'($urandom);
        endcase
    endfunction

    // Random frames of 1..max_len beats; now and then a longer one.
    task automatic run_frames(logic [sba_pkg::MAG_W-1:0] thr, logic [sba_pkg::FC_W-1:0] fpa,
                              int beats, int max_len, idle_mix_t mix);
        int left;
        apply_settings(thr, fpa);
        set_idle_mix(mix);
        left = $urandom_range(1, max_len);
        for (int n = 0; n < beats; n++)
        begin
            left--;
            send_bin(draw_bin(), draw_magnitude(thr), left == 0);
            if (left == 0)
                left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4 * max_len)
                                                   : $urandom_range(1, max_len);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        beats_sent = 0;
        cycle_count = 0;
        sb = new;
        sb.clear();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed frame: ignored low bins, threshold edge, every band edge,
        // a repeated bin, and the frame closed by an ignored bin.
        apply_settings(24'd500, 8'd1);
        set_idle_mix(IDLE_NONE);
        send_bin(0, MAG_MAX, 1'b0);
        send_bin(1, MAG_MAX, 1'b0);
        send_bin(2, 24'd501, 1'b0);
        send_bin(3, 24'd500, 1'b0);
        send_bin(4, 24'd0, 1'b0);
        send_bin(5, MAG_MAX, 1'b0);
        for (int i = 1; i < 9; i++)
        begin
            send_bin(BAND_EDGE[i], sba_pkg::MAG_W'(i * 4099 + 600), 1'b0);
            send_bin(BAND_EDGE[i] + 1, sba_pkg::MAG_W'(i * 70001 + 501), 1'b0);
        end
        send_bin(511, MAG_MAX, 1'b0);
        send_bin(511, MAG_MAX, 1'b0);
        send_bin(0, 24'd0, 1'b1);

        // Heavy frame: full-scale bins pile up a large sum in band 9.
        for (int i = 0; i < 40; i++)
            send_bin(300, MAG_MAX, i == 39);

        // Zero threshold, zero frame count register (acts as one).
        run_frames(24'd0, 8'd0, 45, 8, IDLE_NONE);
        // Full-scale threshold gates everything; heights decay.
        run_frames(MAG_MAX, 8'd2, 20, 6, IDLE_SENDER);
        run_frames(sba_pkg::MAG_W'($urandom_range(200, 3000)), 8'd3, 70, 10, IDLE_RECEIVER);
        // Mostly single-beat frames so a long report comes around.
        run_frames(sba_pkg::MAG_W'($urandom_range(0, 2000)), 8'd130, 130, 1, IDLE_BOTH);
        // Build up frames under a large count, then lower it: the next frame
        // end reports with the actual count as divisor.
        run_frames(sba_pkg::MAG_W'($urandom_range(0, 5000)), 8'd200, 30, 4, IDLE_NONE);
        run_frames(sba_pkg::MAG_W'($urandom), 8'd1, 45, 8, IDLE_SENDER);

        drain();
        $display("%0d bin beats sent, %0d band averages checked over %0d reports",
                 beats_sent, sb.averages_checked, sb.reports);
        $display("thresholds 0 to full scale, frames per report 0 to 200, four idle mixes");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
